// ===== sv/upe_pkg.sv =====
// ----------------------------------------------------------------------------
// upe_pkg: shared types and constants for the url percent encoder
// Command format passed from the classifier to the byte generator, the
// character class test and the hex digit lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package upe_pkg;

  // command kinds held in the queue
  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_PLAIN  = 2'd0;
  localparam cmd_kind_t CMD_ESCAPE = 2'd1;
  localparam cmd_kind_t CMD_REPORT = 2'd2;

  // input operation codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // register byte addresses
  localparam logic [2:0] ADDR_CAPACITY = 3'd0;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;
  localparam logic [7:0]  PERCENT_CHAR   = 8'h25;

  // step indexes within an escape sequence
  localparam logic [1:0] STEP_PERCENT = 2'd0;
  localparam logic [1:0] STEP_HIGH    = 2'd1;
  localparam logic [1:0] STEP_LOW     = 2'd2;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  char_byte;
    logic        ok;
    logic [15:0] length;
  } upe_cmd_t;

  // letters, digits and - _ . ~ pass through unchanged
  function automatic logic is_unreserved(input logic [7:0] c);
    logic res;
    res = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
          ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h2d) || (c == 8'h5f) ||
          (c == 8'h2e) || (c == 8'h7e);
    return res;
  endfunction

  // upper-case hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] res;
    if (n < 4'd10) begin
      res = 8'h30 + {4'd0, n};
    end else begin
      res = 8'h37 + {4'd0, n};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/upe_front.sv =====
// ----------------------------------------------------------------------------
// upe_front: character classifier and length tracker
// Accepts input items, checks each encoding against the capacity and pushes
// one command per item that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module upe_front import upe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_char,
  input  wire logic        accept,
  input  wire logic [15:0] capacity,
  output upe_cmd_t         push_cmd,
  output logic             push
);

  logic [15:0] out_count;
  logic        overflowed;
  logic        plain;
  logic [16:0] sum;
  logic        fits;
  logic        good;

  // classify and check the room left
  always_comb begin
    plain = is_unreserved(in_char);
    sum   = {1'b0, out_count} + (plain ? 17'd1 : 17'd3);
    fits  = sum < {1'b0, capacity};
    good  = !overflowed && (out_count < capacity);
  end

  // command for the byte generator
  always_comb begin
    push_cmd.char_byte = in_char;
    push_cmd.ok        = good;
    push_cmd.length    = good ? out_count : 16'd0;
    if (in_op == OP_END) begin
      push_cmd.kind = CMD_REPORT;
    end else if (plain) begin
      push_cmd.kind = CMD_PLAIN;
    end else begin
      push_cmd.kind = CMD_ESCAPE;
    end
    push = accept && in_valid && ((in_op == OP_END) || (!overflowed && fits));
  end

  // running length and failure flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count  <= 16'd0;
      overflowed <= 1'b0;
    end else if (accept) begin
      if (in_op == OP_END) begin
        out_count  <= 16'd0;
        overflowed <= 1'b0;
      end else if (!overflowed) begin
        if (fits) begin
          out_count <= sum[15:0];
        end else begin
          overflowed <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/upe_queue.sv =====
// ----------------------------------------------------------------------------
// upe_queue: short command queue
// Decouples the classifier from the byte generator.
// ----------------------------------------------------------------------------
`default_nettype none

module upe_queue import upe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire upe_cmd_t push_cmd,
  output logic          not_full,
  input  wire logic     pop,
  output logic          not_empty,
  output upe_cmd_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  upe_cmd_t      entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign not_full  = count != FULL_CNT;
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/upe_back.sv =====
// ----------------------------------------------------------------------------
// upe_back: result byte generator
// Expands each command into one or three bytes or a report, one result per
// cycle while res_ready is high and commands are queued, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module upe_back import upe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_valid,
  input  wire upe_cmd_t q_head,
  output logic          pop,
  output logic          res_valid,
  input  wire logic     res_ready,
  output logic [7:0]    res_byte,
  output logic          res_last,
  output logic          res_report,
  output logic          res_ok,
  output logic [15:0]   res_length
);

  upe_cmd_t   cmd;
  logic       cmd_valid;
  logic [1:0] step;
  logic       last_step;
  logic       out_load;
  logic       cmd_load;
  logic [7:0] gen_byte;

  assign last_step = (cmd.kind != CMD_ESCAPE) || (step == STEP_LOW);
  assign out_load  = cmd_valid && (!res_valid || res_ready);
  assign cmd_load  = !cmd_valid || (out_load && last_step);
  assign pop       = cmd_load && q_valid;

  // byte for the current step
  always_comb begin
    case (cmd.kind)
      CMD_PLAIN:  gen_byte = cmd.char_byte;
      CMD_ESCAPE: begin
        case (step)
          STEP_PERCENT: gen_byte = PERCENT_CHAR;
          STEP_HIGH:    gen_byte = hex_digit(cmd.char_byte[7:4]);
          default:      gen_byte = hex_digit(cmd.char_byte[3:0]);
        endcase
      end
      default:    gen_byte = 8'd0;
    endcase
  end

  // current command and step within it
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      step      <= STEP_PERCENT;
    end else if (cmd_load) begin
      cmd_valid <= q_valid;
      step      <= STEP_PERCENT;
    end else if (out_load) begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd <= q_head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_byte   <= gen_byte;
      res_last   <= last_step;
      res_report <= cmd.kind == CMD_REPORT;
      res_ok     <= (cmd.kind == CMD_REPORT) && cmd.ok;
      res_length <= (cmd.kind == CMD_REPORT) ? cmd.length : 16'd0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/url_percent_encoder_core.sv =====
// ----------------------------------------------------------------------------
// url_percent_encoder_core: percent encoder for byte strings
// Unreserved characters pass through, all others become %XX; a report with
// the final length closes each string.
// ----------------------------------------------------------------------------
// channel   | direction | handshake         | payload
// s_*       | in        | s_tvalid/s_tready | tdata char_byte, tuser operation
// m_*       | out       | m_tvalid/m_tready | tdata out_byte/ok/length,
//           |           |                   | tuser is_report, tlast run_last
// apb       | in        | psel/penable      | capacity at address 0
//
// a plain character gives one result, an escaped one three and an end
// item one; the single-byte-per-cycle result register sets the rate while m_tready is high
// input is taken while the command queue has room, so items enter back to back
// and the classifier runs ahead of the byte generator by up to QUEUE_DEPTH
// commands; characters after a failure give no result
// reset clears length, failure flag, queue and output valid; capacity
// returns to 256
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_encoder_core import upe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
  input  wire logic        s_tuser,   // [0] operation
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] out_byte, [8] ok, [24:9] length, zero pad
  output logic             m_tuser,   // [0] is_report
  output logic             m_tlast,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] capacity;
  upe_cmd_t    push_cmd;
  logic        push;
  logic        q_not_full;
  logic        q_not_empty;
  upe_cmd_t    q_head;
  logic        pop;
  logic        accept;
  logic [7:0]  res_byte;
  logic        res_ok;
  logic [15:0] res_length;

  assign pready   = 1'b1;
  assign s_tready = q_not_full;
  assign accept   = s_tvalid && s_tready;
  assign prdata   = (paddr == ADDR_CAPACITY) ? {16'd0, capacity} : 32'd0;
  assign m_tdata  = {7'd0, res_length, res_ok, res_byte};

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      capacity <= pwdata[15:0];
    end
  end

  upe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_char  (s_tdata),
    .accept   (accept),
    .capacity (capacity),
    .push_cmd (push_cmd),
    .push     (push)
  );

  upe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  upe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_head     (q_head),
    .pop        (pop),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_byte   (res_byte),
    .res_last   (m_tlast),
    .res_report (m_tuser),
    .res_ok     (res_ok),
    .res_length (res_length)
  );

endmodule

`default_nettype wire

// ===== sv/upe_checker.sv =====
// ----------------------------------------------------------------------------
// upe_checker: port-level checks for the url percent encoder
// Watches the result stream for framing and report field rules.
// ----------------------------------------------------------------------------
`default_nettype none

module upe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // a report always closes its item
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == 8'd0))
    else $error("report not marked last or byte not zero");

  // a failed report carries no length
  a_fail_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && !m_tdata[8] |-> m_tdata[24:9] == 16'd0)
    else $error("failed report with nonzero length");

  // byte results carry no status
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[31:8] == 24'd0)
    else $error("byte result with status fields set");

endmodule

bind url_percent_encoder_core upe_checker u_upe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/url_percent_encoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_encoder_checker: result predictor and scoreboard
// Watches the input, result and register channels of the percent encoder.
// Keeps its own copy of the encoded length, the failure flag and the
// capacity, builds the expected result transfers for every accepted input
// and compares each result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module url_percent_encoder_checker import upe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tuser,   // [0] operation
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [7:0] out_byte, [8] ok, [24:9] length, zero pad
  input  logic        m_tuser,   // [0] is_report
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          chars_seen,
  output int          strings_seen,
  output int          strings_failed,
  output int          results_seen
);

  localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic        is_report;
    logic        ok;
    logic [15:0] length;
  } enc_result_t;

  enc_result_t awaited_q[$];
  logic [15:0] capacity_m;
  logic [15:0] enc_len;
  logic        enc_failed;
  int          err_cnt;
  int          char_cnt;
  int          str_cnt;
  int          str_fail_cnt;
  int          res_cnt;

  // letters, digits and the four marks that need no escape
  function automatic logic passes_through(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "-" || c == "_" || c == "." || c == "~";
  endfunction

  function automatic logic [7:0] hex_of(input logic [3:0] nib);
    return HEX_DIGITS[8*(15 - nib) +: 8];
  endfunction

  task automatic await_result(input logic [7:0] b, input logic last, input logic report,
                              input logic good, input logic [15:0] len);
    enc_result_t r;
    r.out_byte  = b;
    r.run_last  = last;
    r.is_report = report;
    r.ok        = good;
    r.length    = len;
    awaited_q.push_back(r);
  endtask

  // expected results of one accepted input transfer
  task automatic encode_item(input logic op, input logic [7:0] c);
    logic        good;
    logic        plain;
    logic [16:0] need;
    if (op == OP_END) begin
      good = !enc_failed && (enc_len < capacity_m);
      await_result(8'h00, 1'b1, 1'b1, good, good ? enc_len : 16'd0);
      str_cnt++;
      if (!good) str_fail_cnt++;
      enc_len    = '0;
      enc_failed = 1'b0;
    end else begin
      char_cnt++;
      if (!enc_failed) begin
        plain = passes_through(c);
        need  = plain ? 17'd1 : 17'd3;
        // no room left for this encoding plus the terminator
        if ({1'b0, enc_len} + need >= {1'b0, capacity_m}) begin
          enc_failed = 1'b1;
        end else begin
          enc_len = enc_len + need[15:0];
          if (plain) begin
            await_result(c, 1'b1, 1'b0, 1'b0, 16'd0);
          end else begin
            await_result(PERCENT_CHAR, 1'b0, 1'b0, 1'b0, 16'd0);
            await_result(hex_of(c[7:4]), 1'b0, 1'b0, 1'b0, 16'd0);
            await_result(hex_of(c[3:0]), 1'b1, 1'b0, 1'b0, 16'd0);
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity_m = CAPACITY_RESET;
      enc_len    = '0;
      enc_failed = 1'b0;
      awaited_q.delete();
      err_cnt      = 0;
      char_cnt     = 0;
      str_cnt      = 0;
      str_fail_cnt = 0;
      res_cnt      = 0;
    end else begin
      // result transfer against the oldest expectation
      if (m_tvalid && m_tready) begin
        res_cnt++;
        if (awaited_q.size() == 0) begin
          $error("result transfer with no expectation waiting, tdata %0h", m_tdata);
          err_cnt++;
        end else begin
          check_field("out_byte", awaited_q[0].out_byte, m_tdata[7:0]);
          check_field("ok", awaited_q[0].ok, m_tdata[8]);
          check_field("length", awaited_q[0].length, m_tdata[24:9]);
          check_field("tdata pad", 32'd0, m_tdata[31:25]);
          check_field("is_report", awaited_q[0].is_report, m_tuser);
          check_field("run_last", awaited_q[0].run_last, m_tlast);
          void'(awaited_q.pop_front());
        end
      end
      // register access
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_CAPACITY) capacity_m = pwdata[15:0];
        end else if (paddr == ADDR_CAPACITY) begin
          check_field("capacity readback", {16'd0, capacity_m}, prdata);
        end
      end
      // input transfer
      if (s_tvalid && s_tready) encode_item(s_tuser, s_tdata);
    end
    errors         <= err_cnt;
    pending        <= awaited_q.size();
    chars_seen     <= char_cnt;
    strings_seen   <= str_cnt;
    strings_failed <= str_fail_cnt;
    results_seen   <= res_cnt;
  end

endmodule

// ===== tb/url_percent_encoder_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_encoder_core_test: stream test of the percent encoder
// Drives boundary characters, overflow and capacity corner cases, then random
// strings over several capacities and idle/stall mixes; the checker beside the
// block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module url_percent_encoder_core_test;
  import upe_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 32;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 35;
  localparam logic [8*19-1:0] BOUNDARY_CHARS = {
    8'h00, 8'hff, 8'h41, 8'h5a, 8'h61, 8'h7a, 8'h30, 8'h39, 8'h2d, 8'h5f,
    8'h2e, 8'h7e, 8'h2f, 8'h3a, 8'h40, 8'h5b, 8'h60, 8'h7b, 8'h7f};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] char_byte
  logic        s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [7:0] out_byte, [8] ok, [24:9] length, zero pad
  logic        m_tuser;   // [0] is_report
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int chars_seen;
  int strings_seen;
  int strings_failed;
  int results_seen;
  int cycle_cnt = 0;
  int send_idle_pct;
  int recv_stall_pct;
  int str_pos;
  int str_target;

  url_percent_encoder_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  url_percent_encoder_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .errors         (errors),
    .pending        (pending),
    .chars_seen     (chars_seen),
    .strings_seen   (strings_seen),
    .strings_failed (strings_failed),
    .results_seen   (results_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one input transfer; tvalid stays high afterwards until the next call or wait_idle
  task automatic send_item(input logic op, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
  endtask

  // all expected results in, then room for items that give none
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(input logic [15:0] cap);
    reg_access(1'b1, ADDR_CAPACITY, {16'd0, cap});
    reg_access(1'b0, ADDR_CAPACITY, 32'd0);
  endtask

  function automatic logic [7:0] plain_char();
    int r;
    r = $urandom_range(65);
    if (r < 26) return 8'h61 + r[7:0];
    if (r < 52) return 8'h41 + r[7:0] - 8'd26;
    if (r < 62) return 8'h30 + r[7:0] - 8'd52;
    case (r)
      62:      return 8'h2d;
      63:      return 8'h5f;
      64:      return 8'h2e;
      default: return 8'h7e;
    endcase
  endfunction

  // mostly whole strings with random content, some stray ends
  task automatic random_strings(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (str_pos >= str_target || $urandom_range(99) < 4) begin
        send_item(OP_END, 8'($urandom_range(255)));
        str_pos    = 0;
        str_target = $urandom_range(24);
      end else begin
        send_item(OP_CHAR, $urandom_range(1) ? plain_char() : 8'($urandom_range(255)));
        str_pos++;
      end
    end
  endtask

  initial begin
    logic [15:0] cap;
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    s_tuser        <= OP_CHAR;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    str_pos        = 0;
    str_target     = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // class boundaries at the reset capacity
    for (int i = 18; i >= 0; i--) send_item(OP_CHAR, BOUNDARY_CHARS[8*i +: 8]);
    send_item(OP_END, 8'hff);
    wait_idle();

    // character that does not fit, then one after the failure
    set_capacity(16'd4);
    send_item(OP_CHAR, "a");
    send_item(OP_CHAR, "b");
    send_item(OP_CHAR, 8'h25);
    send_item(OP_CHAR, "c");
    send_item(OP_END, 8'h00);
    wait_idle();

    // zero capacity: an empty string already fails
    set_capacity(16'd0);
    send_item(OP_END, 8'h00);
    wait_idle();

    // capacity lowered to the current length mid-string
    set_capacity(16'd1000);
    send_item(OP_CHAR, "x");
    send_item(OP_CHAR, "y");
    wait_idle();
    set_capacity(16'd2);
    send_item(OP_END, 8'h00);
    wait_idle();

    // random strings; a string may run across a capacity change
    str_target = $urandom_range(24);
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       cap = 16'hffff;
        1:       cap = 16'd12;
        2:       cap = 16'd256;
        3:       cap = 16'd0;
        4:       cap = 16'd40;
        5:       cap = 16'd1;
        6:       cap = 16'($urandom_range(2, 30));
        default: cap = 16'd7;
      endcase
      wait_idle();
      set_capacity(cap);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 54;
        end
        default: begin
          send_idle_pct = 23;
          recv_stall_pct <= 23;
        end
      endcase
      random_strings(PHASE_ITEMS);
    end
    send_item(OP_END, 8'h00);
    wait_idle();

    $display("covered %0d characters in %0d strings (%0d over capacity)",
             chars_seen, strings_seen, strings_failed);
    $display("%0d result transfers checked, capacities from 0 to 65535", results_seen);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
